// File: hdl/reversible_deque_engine_defines.svh
// Assertion macros used by the verification files of the deque engine.
// No dependencies; the including scope must provide clk and arst_n.
`ifndef REVERSIBLE_DEQUE_ENGINE_DEFINES_SVH
`define REVERSIBLE_DEQUE_ENGINE_DEFINES_SVH

// same-cycle implication
`define RDE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RDE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/rde_pkg.sv
// Shared types and constants of the reversible deque engine.
// No dependencies.
`timescale 1ns / 1ps

package rde_pkg;

	localparam int DEPTH_DEF = 1024;

	localparam logic [2:0] OP_CLEAR   = 3'd0;
	localparam logic [2:0] OP_PUSH    = 3'd1;
	localparam logic [2:0] OP_REVERSE = 3'd2;
	localparam logic [2:0] OP_DELETE  = 3'd3;
	localparam logic [2:0] OP_READ    = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ERR   = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	// result queue behind the pipeline register
	localparam int OQ_DEPTH = 3;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] push_value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] read_value;
		logic               last;
	} res_t;

	// control outcome of one item, registered next to the memory read data
	typedef struct packed {
		logic       valid;
		logic [1:0] status;
		logic       last;
		logic       rd;
	} stage_t;

endpackage

// File: hdl/reversible_deque_engine.sv
// Top level of the reversible deque engine.
// Depends on rde_pkg, rde_ctrl, rde_mem and rde_outq.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------
//   command  | cmd_valid, cmd_ready | cmd (cmd_t)
//   result   | res_valid, res_ready | res (res_t)
//
// One item per cycle sustained while cmd_ready holds; each item's result goes
// through the control register plus registered store read, then the queue.
// cmd_ready comes only from the fill of the three-entry result queue and the
// pipeline register, so a stalled result port holds at most three items.
// Reset clears pointers, count and flags at once; the store is not cleared.
`timescale 1ns / 1ps

module reversible_deque_engine
	import rde_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic               acc;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic signed [31:0] mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;
	logic signed [31:0] mem_rdata;
	stage_t             stage_s1;
	res_t               stage_item;
	logic [OQ_CW-1:0]   q_fill;

	assign cmd_ready = ((OQ_CW + 1)'(q_fill) + (OQ_CW + 1)'(stage_s1.valid))
		< (OQ_CW + 1)'(OQ_DEPTH);
	assign acc = cmd_valid && cmd_ready;

	rde_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.cmd       (cmd),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.stage_s1  (stage_s1)
	);

	rde_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		stage_item.status     = stage_s1.status;
		stage_item.last       = stage_s1.last;
		stage_item.read_value = stage_s1.rd ? mem_rdata : 32'sd0;
	end

	rde_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (stage_s1.valid),
		.push_item (stage_item),
		.pop       (res_valid && res_ready),
		.valid     (res_valid),
		.head_item (res),
		.fill      (q_fill)
	);

endmodule

// File: hdl/rde_mem.sv
// Element store: one write port, one registered read port.
// Depends on rde_pkg for the default depth.
`timescale 1ns / 1ps

module rde_mem
	import rde_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic signed [31:0]   wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output logic signed [31:0]   rdata
);

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/rde_ctrl.sv
// Deque pointer, count and flag logic; drives the element store ports.
// Depends on rde_pkg.
`timescale 1ns / 1ps

module rde_ctrl
	import rde_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               acc,
	input  cmd_t               cmd,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output logic signed [31:0] mem_wdata,
	output logic               mem_re,
	output logic [AW-1:0]      mem_raddr,
	output stage_t             stage_s1
);

	localparam int SW = CW + 1;
	localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
	localparam logic [AW-1:0] TOP_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [AW-1:0] head_q, head_n;
	logic [CW-1:0] count_q, count_n;
	logic          rev_q, rev_n;
	logic          err_q, err_n;

	logic [SW-1:0] sum_tail;
	logic [SW-1:0] tail_w;
	logic [AW-1:0] tail_idx;
	logic [AW-1:0] back_idx;
	logic [AW-1:0] head_inc;
	logic [AW-1:0] front_idx;
	logic          empty;
	logic          full;
	logic          known_op;
	logic [1:0]    status;
	logic          last;
	logic          rd;

	logic          valid_s1;
	logic [1:0]    status_s1;
	logic          last_s1;
	logic          rd_s1;

	always_comb begin
		sum_tail  = SW'(head_q) + SW'(count_q);
		tail_w    = (sum_tail >= DEPTH_S) ? (sum_tail - DEPTH_S) : sum_tail;
		tail_idx  = tail_w[AW-1:0];
		back_idx  = (tail_idx == '0) ? TOP_IDX : (tail_idx - 1'b1);
		head_inc  = (head_q == TOP_IDX) ? '0 : (head_q + 1'b1);
		front_idx = rev_q ? back_idx : head_q;
		empty     = (count_q == '0);
		full      = (count_q >= FULL_CNT);
		known_op  = (cmd.op == OP_PUSH) || (cmd.op == OP_REVERSE) ||
			(cmd.op == OP_DELETE) || (cmd.op == OP_READ);

		head_n    = head_q;
		count_n   = count_q;
		rev_n     = rev_q;
		err_n     = err_q;
		status    = ST_OK;
		last      = 1'b0;
		rd        = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = tail_idx;
		mem_wdata = cmd.push_value;
		mem_raddr = front_idx;

		if (cmd.op == OP_CLEAR) begin
			head_n  = '0;
			count_n = '0;
			rev_n   = 1'b0;
			err_n   = 1'b0;
		end else if (known_op && err_q) begin
			status = ST_ERR;
		end else if (cmd.op == OP_PUSH) begin
			if (full) begin
				status = ST_FULL;
			end else begin
				mem_we  = acc;
				count_n = count_q + 1'b1;
			end
		end else if (cmd.op == OP_REVERSE) begin
			if (!empty) begin
				rev_n = !rev_q;
			end
		end else if (cmd.op == OP_DELETE || cmd.op == OP_READ) begin
			if (empty) begin
				if (cmd.op == OP_DELETE) begin
					err_n  = 1'b1;
					status = ST_ERR;
				end else begin
					status = ST_EMPTY;
				end
			end else begin
				count_n = count_q - 1'b1;
				if (!rev_q) begin
					head_n = head_inc;
				end
				if (cmd.op == OP_READ) begin
					mem_re = acc;
					rd     = 1'b1;
					last   = (count_q == CW'(1));
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			rev_q    <= 1'b0;
			err_q    <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc;
			if (acc) begin
				head_q  <= head_n;
				count_q <= count_n;
				rev_q   <= rev_n;
				err_q   <= err_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1 <= status;
			last_s1   <= last;
			rd_s1     <= rd;
		end
	end

	assign stage_s1 = '{valid: valid_s1, status: status_s1, last: last_s1, rd: rd_s1};

endmodule

// File: hdl/rde_outq.sv
// Small result queue between the pipeline register and the result port.
// Depends on rde_pkg.
`timescale 1ns / 1ps

module rde_outq
	import rde_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  res_t             push_item,
	input  logic             pop,
	output logic             valid,
	output res_t             head_item,
	output logic [OQ_CW-1:0] fill
);

	localparam logic [OQ_AW-1:0] LAST_PTR = OQ_AW'(OQ_DEPTH - 1);

	res_t             entry_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wp_q;
	logic [OQ_AW-1:0] rp_q;
	logic [OQ_CW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == LAST_PTR) ? '0 : (wp_q + 1'b1);
			end
			if (pop) begin
				rp_q <= (rp_q == LAST_PTR) ? '0 : (rp_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wp_q] <= push_item;
		end
	end

	assign valid     = (cnt_q != '0);
	assign head_item = entry_q[rp_q];
	assign fill      = cnt_q;

endmodule

// File: hdl/rde_checker.sv
// Port-level checks of the reversible deque engine, bound to the top level.
// Depends on rde_pkg and reversible_deque_engine_defines.svh.
`timescale 1ns / 1ps
`include "reversible_deque_engine_defines.svh"

module rde_checker
	import rde_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input cmd_t cmd,
	input logic res_valid,
	input logic res_ready,
	input res_t res
);

	logic [2:0] pend_q;
	logic       cmd_acc;
	logic       res_acc;

	assign cmd_acc = cmd_valid && cmd_ready;
	assign res_acc = res_valid && res_ready;

	// items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (cmd_acc && !res_acc) begin
			pend_q <= pend_q + 1'b1;
		end else if (res_acc && !cmd_acc) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	`RDE_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "result changed while stalled")
	`RDE_ASSERT_NOW(a_no_phantom, res_valid, pend_q != 3'd0, "result without a pending item")
	`RDE_ASSERT_NOW(a_ready_bound, cmd_ready, pend_q <= 3'd2, "ready with too many items in flight")
	`RDE_ASSERT_NOW(a_fail_clean, res_valid && res.status != ST_OK, res.read_value == 32'sd0 && !res.last, "failed item carries data")

endmodule

bind reversible_deque_engine rde_checker u_rde_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.cmd       (cmd),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);
